// ----- design/mkh_pkg.sv -----
package mkh_pkg;

  localparam logic [31:0] MixMul     = 32'h5bd1_e995;
  localparam int unsigned MixShift   = 24;
  localparam int unsigned FinShiftA  = 13;
  localparam int unsigned FinShiftB  = 15;
  localparam logic [31:0] SeedReset  = 32'd97;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_LOAD = 3'd1,  // capture word, seed the running hash on a first word
    OP_K1   = 3'd2,  // k = k * m
    OP_K2   = 3'd3,  // k = (k ^ k >> 24) * m
    OP_HMIX = 3'd4,  // h = (h * m) ^ k
    OP_TAIL = 3'd5,  // h = (h ^ tail) * m
    OP_FIN  = 3'd6   // f = (h ^ h >> 13) * m
  } dp_op_e;

  typedef struct packed {
    logic in_full;  // incoming word carries four or more bytes
    logic in_part;  // incoming word carries one to three bytes
    logic last_q;   // captured word ends its key
  } dp_status_t;

endpackage

// ----- design/mkh_datapath.sv -----
module mkh_datapath
  import mkh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_op_e      op_i,
  output dp_status_t  status_o,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic [31:0] key_word_i,
  input  logic [2:0]  word_bytes_i,
  input  logic        is_first_i,
  input  logic        is_last_i,
  input  logic [31:0] total_length_i,
  output logic [31:0] hash_value_o
);

  logic [31:0] seed_q;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [31:0] f_q, f_d;
  logic        last_q, last_d;
  logic [31:0] byte_mask;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    case (word_bytes_i)
      3'd1:    byte_mask = 32'h0000_00ff;
      3'd2:    byte_mask = 32'h0000_ffff;
      3'd3:    byte_mask = 32'h00ff_ffff;
      default: byte_mask = 32'hffff_ffff;
    endcase
  end

  assign status_o.in_full = word_bytes_i[2];
  assign status_o.in_part = !word_bytes_i[2] && (word_bytes_i != 3'd0);
  assign status_o.last_q  = last_q;

  // Single shared constant multiplier; operand picked per operation.
  always_comb begin
    case (op_i)
      OP_K1:   mul_a = k_q;
      OP_K2:   mul_a = k_q ^ (k_q >> MixShift);
      OP_HMIX: mul_a = h_q;
      OP_TAIL: mul_a = h_q ^ k_q;
      OP_FIN:  mul_a = h_q ^ (h_q >> FinShiftA);
      default: mul_a = h_q;
    endcase
  end

  assign prod = mul_a * MixMul;

  always_comb begin
    h_d    = h_q;
    k_d    = k_q;
    f_d    = f_q;
    last_d = last_q;
    case (op_i)
      OP_LOAD: begin
        h_d    = is_first_i ? (seed_q ^ total_length_i) : h_q;
        k_d    = key_word_i & byte_mask;
        last_d = is_last_i;
      end
      OP_K1, OP_K2: k_d = prod;
      OP_HMIX:      h_d = prod ^ k_q;
      OP_TAIL:      h_d = prod;
      OP_FIN:       f_d = prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
      h_q    <= '0;
      last_q <= 1'b0;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
      h_q    <= h_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    f_q <= f_d;
  end

  assign hash_value_o = f_q ^ (f_q >> FinShiftB);

endmodule

// ----- design/mkh_ctrl.sv -----
module mkh_ctrl
  import mkh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MIX1 = 6'b000010,
    ST_MIX2 = 6'b000100,
    ST_MIX3 = 6'b001000,
    ST_TAIL = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LOAD;
          if (status_i.in_full) begin
            state_d = ST_MIX1;
          end else if (status_i.in_part) begin
            state_d = ST_TAIL;
          end else begin
            // empty word: finalize straight away if it ends the key
            state_d = ST_FIN;
          end
        end
      end
      ST_MIX1: begin
        op_o    = OP_K1;
        state_d = ST_MIX2;
      end
      ST_MIX2: begin
        op_o    = OP_K2;
        state_d = ST_MIX3;
      end
      ST_MIX3: begin
        op_o    = OP_HMIX;
        state_d = ST_FIN;
      end
      ST_TAIL: begin
        op_o    = OP_TAIL;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!status_i.last_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          op_o        = OP_FIN;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/murmur2_key_hasher_top.sv -----
// Streaming 32-bit MurmurHash2 (multiplier 0x5bd1e995, shift 24). Send a key
// as little-endian 32-bit words, first byte in bits 7:0; mark the first word
// with is_first_i (it seeds the hash with hash_seed XOR total_length_i) and
// the final word with is_last_i. Only the last word may carry fewer than four
// bytes; an empty key is a single word with zero bytes. One hash word comes
// out per key. One constant multiplier does every multiply: a full word goes
// through accept, three multiplies and a check/finalize step, a 1-3 byte word
// through accept, a tail multiply and that step, an empty word through accept
// and that step; a last word finalizes there. The finished hash sits in an
// output register, so the next word is taken while the result waits; the
// block stalls only when a second result is ready before the first is taken.
// The seed may be written on the cfg port only while no key is in flight.
module murmur2_key_hasher_top
  import mkh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: hash seed
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] hash_seed_i,
  // key word input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] key_word_i,
  input  logic [2:0]  word_bytes_i,
  input  logic        is_first_i,
  input  logic        is_last_i,
  input  logic [31:0] total_length_i,
  // hash result
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hash_value_o
);

  dp_op_e     op;
  dp_status_t status;

  // Seed writes are always taken.
  assign cfg_ready_o = 1'b1;

  mkh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .op_o        (op)
  );

  mkh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .status_o       (status),
    .seed_we_i      (cfg_valid_i),
    .seed_i         (hash_seed_i),
    .key_word_i     (key_word_i),
    .word_bytes_i   (word_bytes_i),
    .is_first_i     (is_first_i),
    .is_last_i      (is_last_i),
    .total_length_i (total_length_i),
    .hash_value_o   (hash_value_o)
  );

endmodule

// ----- tb/testbench.sv -----
module testbench
  import mkh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound for ~1750 words, plus drains.
  localparam int unsigned CycleLimit = 400000;
  // Cycles a word may still spend inside the block after the last hash is out.
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned WordTarget = 1750;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] hash_seed_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] key_word_i;
  logic [2:0]  word_bytes_i;
  logic        is_first_i;
  logic        is_last_i;
  logic [31:0] total_length_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] hash_value_o;

  // Shadow copy of the block's state, advanced on every accepted word.
  logic [31:0] seed_shadow;
  logic [31:0] hash_acc;
  logic [31:0] expected_hashes[$];

  logic        idle_on;      // random gaps and stalls enabled
  int unsigned words_sent;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned stall_left;
  logic [31:0] exp_hash;

  murmur2_key_hasher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .hash_seed_i   (hash_seed_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_word_i    (key_word_i),
    .word_bytes_i  (word_bytes_i),
    .is_first_i    (is_first_i),
    .is_last_i     (is_last_i),
    .total_length_i(total_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hash_value_o  (hash_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Fold one accepted word into the shadow hash; queue the finalized hash
  // when the word closes its key.
  function automatic void absorb_word(input logic [31:0] kw, input logic [2:0] nb,
                                      input logic first, input logic last,
                                      input logic [31:0] total);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] mask;
    int unsigned n;
    // Counts above four saturate to a full word.
    n = (nb > 3'd4) ? 4 : int'(nb);
    h = first ? (seed_shadow ^ total) : hash_acc;
    if (n == 4) begin
      k = kw * MixMul;
      k = k ^ (k >> MixShift);
      k = k * MixMul;
      h = (h * MixMul) ^ k;
    end else if (n != 0) begin
      // Tail bytes: mask off everything above the count, even mid-key.
      mask = (32'd1 << (8 * n)) - 32'd1;
      h = (h ^ (kw & mask)) * MixMul;
    end
    // The running hash keeps its unfinalized value after the last word.
    hash_acc = h;
    if (last) begin
      h = h ^ (h >> FinShiftA);
      h = h * MixMul;
      h = h ^ (h >> FinShiftB);
      expected_hashes.push_back(h);
    end
  endfunction

  // Present one word after a random gap, hold it until taken, then predict.
  task automatic send_word(input logic [31:0] kw, input logic [2:0] nb,
                           input logic first, input logic last,
                           input logic [31:0] total);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    key_word_i     <= kw;
    word_bytes_i   <= nb;
    is_first_i     <= first;
    is_last_i      <= last;
    total_length_i <= total;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_word(kw, nb, first, last, total);
    words_sent++;
  endtask

  // Split a key of len bytes into words; empty keys are one zero-byte word.
  task automatic send_key(input int unsigned len, input logic [31:0] total,
                          input logic with_first);
    int unsigned left;
    int unsigned nb;
    logic [2:0]  code;
    left = len;
    if (len == 0) begin
      send_word($urandom, 3'd0, with_first, 1'b1, total);
    end else begin
      while (left > 0) begin
        nb = (left > 4) ? 4 : left;
        code = 3'(nb);
        // Now and then flag a full word with an oversized count.
        if (nb == 4 && $urandom_range(0, 15) == 0) code = 3'($urandom_range(5, 7));
        send_word($urandom, code, with_first && left == len, left == nb, total);
        left -= nb;
      end
    end
  endtask

  // Drop valid, wait for every queued hash, then let in-flight words settle.
  task automatic wait_hashes_out();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_hashes.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the seed only once the block is idle.
  task automatic write_seed(input logic [31:0] seed);
    wait_hashes_out();
    cfg_valid_i <= 1'b1;
    hash_seed_i <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seed_shadow = seed;
  endtask

  // Reset seed, field extremes and every special case of the stream format.
  task automatic test_directed_words();
    idle_on = 1'b1;
    // empty keys, length extremes
    send_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000);
    send_word(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'hffff_ffff);
    // single full words
    send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'd4);
    send_word(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'd4);
    // short keys with junk above the counted bytes
    send_word(32'hdead_be41, 3'd1, 1'b1, 1'b1, 32'd1);
    send_word(32'h1234_5678, 3'd2, 1'b1, 1'b1, 32'd2);
    send_word(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'd3);
    // oversized counts behave as four
    send_word(32'ha5a5_a5a5, 3'd5, 1'b1, 1'b1, 32'd4);
    send_word(32'h5a5a_5a5a, 3'd6, 1'b1, 1'b1, 32'd4);
    send_word(32'h8000_0001, 3'd7, 1'b1, 1'b1, 32'd4);
    // eleven-byte key: two full words and a tail
    send_word(32'h0102_0304, 3'd4, 1'b1, 1'b0, 32'd11);
    send_word(32'h0506_0708, 3'd4, 1'b0, 1'b0, 32'd11);
    send_word(32'hff0b_0a09, 3'd3, 1'b0, 1'b1, 32'd11);
    // partial word in the middle of a key is still folded as a tail
    send_word(32'haabb_ccdd, 3'd2, 1'b1, 1'b0, 32'd9);
    send_word(32'h1122_3344, 3'd4, 1'b0, 1'b0, 32'd9);
    send_word(32'h5566_7788, 3'd3, 1'b0, 1'b1, 32'd9);
    // no first flag: continue from the hash left by the finished key
    send_word(32'hcafe_f00d, 3'd4, 1'b0, 1'b1, 32'd0);
    // last word with no bytes, not first: finalize the running hash as is
    send_word(32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'd0);
    // zero-byte first word that does not end the key
    send_word(32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'hffff_ffff);
    send_word(32'hffff_ffff, 3'd4, 1'b0, 1'b1, 32'd0);
    // length field that disagrees with the data
    send_word(32'h8000_0000, 3'd4, 1'b1, 1'b1, 32'h8000_0000);
  endtask

  // Walk the seed through its extremes and a random value with a few keys under each.
  task automatic test_seed_values();
    write_seed(32'h0000_0000);
    send_key(0, 32'd0, 1'b1);
    send_key(7, 32'd7, 1'b1);
    write_seed(32'hffff_ffff);
    send_key(0, 32'd0, 1'b1);
    send_key(13, 32'd13, 1'b1);
    write_seed($urandom);
    send_key(4, 32'd4, 1'b1);
    send_key(22, 32'd22, 1'b1);
  endtask

  // Pause the sender with results outstanding until all of them drain.
  task automatic test_drain_pause();
    idle_on = 1'b0;
    send_key(9, 32'd9, 1'b1);
    send_key(1, 32'd1, 1'b1);
    send_key(16, 32'd16, 1'b1);
    wait_hashes_out();
    send_key(5, 32'd5, 1'b1);
    idle_on = 1'b1;
  endtask

  // Mostly well-formed keys with random content, the rest noise and broken
  // sequences; a new seed per phase and one phase without gaps or stalls.
  task automatic test_random_keys();
    int unsigned phase;
    int unsigned pick;
    int unsigned len;
    int unsigned nfull;
    logic [31:0] total;
    phase = 0;
    while (words_sent < WordTarget) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 24);
      total = ($urandom_range(0, 7) == 0) ? $urandom : len;
      if (pick < 80) begin
        send_key(len, total, 1'b1);
      end else if (pick < 87) begin
        // raw noise word
        send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom);
      end else if (pick < 92) begin
        // key that never marks its first word
        send_key(len, total, 1'b0);
      end else if (pick < 96) begin
        // key cut short: full words only, no last word
        nfull = $urandom_range(1, 4);
        for (int i = 0; i < nfull; i++) begin
          send_word($urandom, 3'd4, i == 0, 1'b0, total);
        end
      end else begin
        // stray partial word, then the rest of the key
        send_word($urandom, 3'($urandom_range(1, 3)), 1'b1, 1'b0, total);
        send_key(len, total, 1'b0);
      end
      if (words_sent >= (phase + 1) * (WordTarget / 4) && words_sent < WordTarget) begin
        phase++;
        // close any open key before touching the seed
        send_key($urandom_range(0, 8), $urandom, 1'b1);
        write_seed($urandom);
        idle_on = (phase != 2);
      end
    end
  endtask

  // Check each hash word taken from the block; draw a new stall after each.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected hash word: expected none, actual %h",
                   $time, hash_value_o);
          mismatches++;
        end else begin
          exp_hash = expected_hashes.pop_front();
          if (hash_value_o !== exp_hash) begin
            $display("%0t: hash_value mismatch: expected %h, actual %h",
                     $time, exp_hash, hash_value_o);
            mismatches++;
          end
        end
        stall_left = idle_on ? $urandom_range(0, 6) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    hash_seed_i    = '0;
    in_valid_i     = 1'b0;
    key_word_i     = '0;
    word_bytes_i   = '0;
    is_first_i     = 1'b0;
    is_last_i      = 1'b0;
    total_length_i = '0;
    out_ready_i    = 1'b0;
    idle_on        = 1'b1;
    words_sent     = 0;
    mismatches     = 0;
    cycle_count    = 0;
    stall_left     = 0;
    seed_shadow    = SeedReset;
    hash_acc       = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_words();
    test_seed_values();
    test_drain_pause();
    test_random_keys();

    // Let every outstanding hash come out, then settle.
    wait_hashes_out();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- murmur2_key_hasher_top.f -----
design/mkh_pkg.sv
design/mkh_datapath.sv
design/mkh_ctrl.sv
design/murmur2_key_hasher_top.sv
tb/testbench.sv
